@@ src/dttf_pkg.sv @@
// Shared constants, widths and types for the decimal text to fixed point converter.
`default_nettype none
package dttf_pkg;

    localparam int INT_BITS        = 31;
    localparam int FRAC_BITS       = 16;
    localparam int MAX_FRAC_DIGITS = 9;
    localparam int OUT_W           = 48;

    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;
    localparam int FW      = $clog2(64'd10 ** MAX_FRAC_DIGITS + 64'd1);
    localparam int CNT_W   = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int PROD_W  = INT_BITS + 4;
    localparam int STEP_W  = $clog2(FRAC_BITS + 1);
    localparam int MAG_W   = INT_BITS + FRAC_BITS;
    localparam int EXT_W   = (MAG_W > OUT_W) ? MAG_W : OUT_W;
    localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_INT   = 2'd1;
    localparam logic [1:0] PH_FRAC  = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    typedef struct packed {
        logic                is_negative;
        logic                saturated;
        logic [INT_BITS-1:0] int_mag;
        logic [FW-1:0]       frac_num;
        logic [FW-1:0]       frac_den;
    } parse_state_t;

endpackage
`default_nettype wire

@@ src/decimal_text_to_fixed_point.sv @@
// Top level: stream ports, sequencer and output register of the text to fixed point converter.
//
// One character is taken per cycle while s_tready is high. The character flagged by s_tlast
// starts the fraction division, which runs one quotient bit per cycle through a single shared
// subtract-and-compare unit to form the fraction bits of the Q31.16 result. The input is not
// ready during the division. A result waits in the output register while the next string is
// already taken in. The result is the signed Q31.16 value in m_tdata and the integer overflow
// flag in m_tuser.
`default_nettype none
module decimal_text_to_fixed_point (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [dttf_pkg::CHAR_W-1:0]     s_tdata,  // [7:0] char_code
    input  wire logic                            s_tlast,  // last_char
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [dttf_pkg::TDATA_W-1:0]         m_tdata,  // [47:0] fixed_value
    output logic [0:0]                           m_tuser   // [0] overflow
);
    import dttf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0]   out_data_reg;
    logic                 out_flag_reg;

    parse_state_t         pstate;
    logic                 take;
    logic                 finish;
    logic                 div_done;
    logic [FRAC_BITS-1:0] quotient;
    logic [EXT_W-1:0]     mag_ext;
    logic [EXT_W-1:0]     signed_val;

    assign s_tready = (state_reg == ST_IDLE);
    assign take     = s_tvalid && s_tready;
    assign finish   = (state_reg == ST_DIV) && div_done && (!out_valid_reg || m_tready);

    dttf_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .char_code (s_tdata),
        .clear     (finish),
        .state     (pstate)
    );

    dttf_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_LOAD),
        .ack      (finish),
        .num      (pstate.frac_num),
        .den      (pstate.frac_den),
        .done     (div_done),
        .quotient (quotient)
    );

    assign mag_ext    = EXT_W'({pstate.int_mag, quotient});
    assign signed_val = pstate.is_negative ? (EXT_W'(0) - mag_ext) : mag_ext;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (take && s_tlast)
                    state_next = ST_LOAD;
            ST_LOAD:
                state_next = ST_DIV;
            ST_DIV:
                if (finish)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        if (finish)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_data_reg <= TDATA_W'(signed_val[OUT_W-1:0]);
            out_flag_reg <= pstate.saturated;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_flag_reg;

endmodule
`default_nettype wire

@@ src/dttf_parser.sv @@
// Character parser: sign, integer and fraction accumulators with shift-add times ten.
`default_nettype none
module dttf_parser (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       take,
    input  wire logic [dttf_pkg::CHAR_W-1:0] char_code,
    input  wire logic                       clear,
    output dttf_pkg::parse_state_t          state
);
    import dttf_pkg::*;

    localparam logic [PROD_W-1:0] INT_MAX = PROD_W'({INT_BITS{1'b1}});

    logic [1:0]          phase_reg, phase_next;
    logic                neg_reg, neg_next;
    logic                sat_reg, sat_next;
    logic [INT_BITS-1:0] int_reg, int_next;
    logic [FW-1:0]       num_reg, num_next;
    logic [FW-1:0]       den_reg, den_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic                is_digit;
    logic [DIGIT_W-1:0]  digit;
    logic [PROD_W-1:0]   int_wide;
    logic [PROD_W-1:0]   prod;
    logic                int_add;
    logic                frac_add;

    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign digit    = char_code[DIGIT_W-1:0];
    assign int_wide = PROD_W'(int_reg);
    assign prod     = (int_wide << 3) + (int_wide << 1) + PROD_W'(digit);

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        int_add    = 1'b0;
        frac_add   = 1'b0;
        case (phase_reg)
            PH_START:
            begin
                if (char_code == CH_PLUS || char_code == CH_MINUS)
                begin
                    neg_next   = (char_code == CH_MINUS);
                    phase_next = PH_INT;
                end
                else if (is_digit)
                begin
                    int_add    = 1'b1;
                    phase_next = PH_INT;
                end
                else if (char_code == CH_POINT)
                    phase_next = PH_FRAC;
                else
                    phase_next = PH_STOP;
            end
            PH_INT:
            begin
                if (is_digit)
                    int_add = 1'b1;
                else if (char_code == CH_POINT)
                    phase_next = PH_FRAC;
                else
                    phase_next = PH_STOP;
            end
            PH_FRAC:
            begin
                if (is_digit)
                    frac_add = (cnt_reg < CNT_W'(MAX_FRAC_DIGITS));
                else
                    phase_next = PH_STOP;
            end
            default:
                phase_next = PH_STOP;
        endcase

        int_next = int_reg;
        sat_next = sat_reg;
        if (int_add)
        begin
            if (prod > INT_MAX)
            begin
                int_next = {INT_BITS{1'b1}};
                sat_next = 1'b1;
            end
            else
                int_next = prod[INT_BITS-1:0];
        end

        num_next = num_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        if (frac_add)
        begin
            num_next = (num_reg << 3) + (num_reg << 1) + FW'(digit);
            den_next = (den_reg << 3) + (den_reg << 1);
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            neg_reg   <= 1'b0;
            sat_reg   <= 1'b0;
            int_reg   <= '0;
            num_reg   <= '0;
            den_reg   <= FW'(1);
            cnt_reg   <= '0;
        end
        else if (clear)
        begin
            phase_reg <= PH_START;
            neg_reg   <= 1'b0;
            sat_reg   <= 1'b0;
            int_reg   <= '0;
            num_reg   <= '0;
            den_reg   <= FW'(1);
            cnt_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            sat_reg   <= sat_next;
            int_reg   <= int_next;
            num_reg   <= num_next;
            den_reg   <= den_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign state.is_negative = neg_reg;
    assign state.saturated   = sat_reg;
    assign state.int_mag     = int_reg;
    assign state.frac_num    = num_reg;
    assign state.frac_den    = den_reg;

endmodule
`default_nettype wire

@@ src/dttf_divider.sv @@
// Restoring binary divider: one quotient bit of the fraction per cycle.
`default_nettype none
module dttf_divider (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          ack,
    input  wire logic [dttf_pkg::FW-1:0]       num,
    input  wire logic [dttf_pkg::FW-1:0]       den,
    output logic                               done,
    output logic [dttf_pkg::FRAC_BITS-1:0]     quotient
);
    import dttf_pkg::*;

    logic                 busy_reg, busy_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [FW:0]          rem_reg, rem_next;
    logic [FRAC_BITS-1:0] q_reg, q_next;
    logic [FW:0]          shifted;
    logic [FW:0]          den_ext;
    logic                 fits;

    assign shifted = rem_reg << 1;
    assign den_ext = {1'b0, den};
    assign fits    = (shifted >= den_ext);

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(FRAC_BITS);
            rem_next  = {1'b0, num};
            q_next    = '0;
        end
        else if (busy_reg && (step_reg != '0))
        begin
            step_next = step_reg - STEP_W'(1);
            rem_next  = fits ? (shifted - den_ext) : shifted;
            q_next    = {q_reg[FRAC_BITS-2:0], fits};
        end
        else if (ack)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done     = busy_reg && (step_reg == '0);
    assign quotient = q_reg;

endmodule
`default_nettype wire

@@ src/dttf_checker.sv @@
// Port-level checker for the text to fixed point converter, bound to the top level.
`default_nettype none
module dttf_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic                          s_tlast,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [dttf_pkg::TDATA_W-1:0]  m_tdata,
    input  wire logic [0:0]                    m_tuser
);
    import dttf_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready ##1 !s_tready)
        else $error("input ready during division");

    a_result_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without a finished division");

    a_no_result_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast && !m_tvalid |=> !m_tvalid)
        else $error("result appeared before division");

    a_overflow_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] && !m_tdata[OUT_W-1] |-> m_tdata[FRAC_BITS +: INT_BITS] == '1)
        else $error("overflow flag without saturated integer");

endmodule

bind decimal_text_to_fixed_point dttf_checker u_dttf_checker (.*);
`default_nettype wire
